/* hw/rtl/chte_pkg.sv */
// Shared types and constants of the chained hash table engine.
`timescale 1ns / 1ps
`default_nettype none
package chte_pkg;

  localparam int NUM_BUCKETS_DEF  = 1024;
  localparam int POOL_ENTRIES_DEF = 1024;

  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int BIDX_W   = 10;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    logic [BIDX_W-1:0] bucket;
    logic [VAL_W-1:0]  value;
  } req_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RED,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_HEAD,
    B_LINK,
    B_CMP,
    B_FREE,
    B_INS,
    B_DONE
  } back_state_t;

endpackage
`default_nettype wire

/* hw/rtl/chte_if.sv */
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface chte_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] key;
  logic [9:0]  bucket_index;
  logic [31:0] entry_value;
  modport source (output valid, mode, key, bucket_index, entry_value, input ready);
  modport sink (input valid, mode, key, bucket_index, entry_value, output ready);
endinterface

interface chte_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  modport source (output valid, status, found_value, input ready);
  modport sink (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/chained_hash_table_engine_unit.sv */
// Top level of the chained hash table engine.
//
//   Channel  Dir  Handshake      Payload
//   in_ch    in   valid/ready    mode, key, bucket_index, entry_value
//   out_ch   out  valid/ready    status, found_value
//
// The intake takes no new request until it has pushed the last one into the
// queue; its bucket reduction runs two compare-subtract steps per cycle. The
// walker reads the bucket head, then for lookup and delete compares one chain
// entry after another and frees the entry when a delete hits; an insert links
// a new entry at the head. After reset all bucket heads are cleared, and no
// request is taken until that is done. A stalled result holds only the
// walker; the intake and its two-entry queue keep filling.
`timescale 1ns / 1ps
`default_nettype none
module chained_hash_table_engine_unit
  import chte_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  chte_in_if.sink    in_ch,
  chte_out_if.source out_ch
);

  logic       q_push, q_pop, q_full, q_valid;
  req_t       q_in, q_out;
  logic [1:0] q_count;
  back_stat_t stat;

  chte_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .stat   (stat),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  chte_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .full      (q_full),
    .valid     (q_valid),
    .pop_data  (q_out),
    .count     (q_count)
  );

  chte_back #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .stat    (stat),
    .out_ch  (out_ch)
  );

  a_no_intake_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_ch.ready)
    else $error("request taken during bucket clear");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= 2'd2 && !(q_push && q_full))
    else $error("request queue overflow");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty request queue");

endmodule
`default_nettype wire

/* hw/rtl/chte_front.sv */
// Request intake: takes a transfer and reduces its bucket index modulo the bucket count.
`timescale 1ns / 1ps
`default_nettype none
module chte_front
  import chte_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  chte_in_if.sink         in_ch,
  input  wire back_stat_t stat,
  input  wire logic       q_full,
  output      logic       q_push,
  output      req_t       q_data
);

  localparam int DIVW = 27;

  front_state_t      state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  logic [BIDX_W-1:0] rem_r, rem_nxt;
  req_t              req_r, req_nxt;
  logic [DIVW-1:0]   div_hi, div_lo;
  logic [BIDX_W-1:0] rem_mid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    req_r  <= req_nxt;
  end

  always_comb begin
    div_hi  = DIVW'(NUM_BUCKETS) << {step_r, 1'b1};
    div_lo  = DIVW'(NUM_BUCKETS) << {step_r, 1'b0};
    rem_mid = (DIVW'(rem_r) >= div_hi) ? rem_r - div_hi[BIDX_W-1:0] : rem_r;
    state_nxt   = state_r;
    step_nxt    = step_r;
    rem_nxt     = rem_r;
    req_nxt     = req_r;
    in_ch.ready = 1'b0;
    q_push      = 1'b0;
    q_data      = req_r;
    q_data.bucket = rem_r;
    case (state_r)
      F_IDLE: begin
        in_ch.ready = !stat.clearing;
        if (in_ch.valid && !stat.clearing) begin
          req_nxt.mode   = in_ch.mode;
          req_nxt.key    = in_ch.key;
          req_nxt.value  = in_ch.entry_value;
          req_nxt.bucket = in_ch.bucket_index;
          rem_nxt        = in_ch.bucket_index;
          step_nxt       = 3'd4;
          state_nxt      = F_RED;
        end
      end
      F_RED: begin
        rem_nxt = (DIVW'(rem_mid) >= div_lo) ? rem_mid - div_lo[BIDX_W-1:0] : rem_mid;
        step_nxt = step_r - 3'd1;
        if (step_r == 3'd0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/chte_queue.sv */
// Two-entry request queue between the intake and the table walker.
`timescale 1ns / 1ps
`default_nettype none
module chte_queue
  import chte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire req_t push_data,
  input  wire logic pop,
  output      logic full,
  output      logic valid,
  output      req_t pop_data,
  output      logic [1:0] count
);

  req_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
    full       = (count_r == 2'd2);
    valid      = (count_r != 2'd0);
    pop_data   = slot_r[rd_ptr_r];
    count      = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/chte_back.sv */
// Table walker: bucket heads, entry pool, free list and the result register.
`timescale 1ns / 1ps
`default_nettype none
module chte_back
  import chte_pkg::*;
#(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire req_t q_data,
  output      logic q_pop,
  output      back_stat_t stat,
  chte_out_if.source out_ch
);

  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int LW = $clog2(POOL_ENTRIES + 1);
  localparam logic [LW-1:0] LINK_NULL = LW'(POOL_ENTRIES);

  logic [LW-1:0]    bh_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] key_mem [POOL_ENTRIES];
  logic [VAL_W-1:0] dat_mem [POOL_ENTRIES];
  logic [LW-1:0]    nx_mem [POOL_ENTRIES];

  logic             bh_we, ent_we, nx_we;
  logic [BW-1:0]    bh_waddr, bh_raddr;
  logic [LW-1:0]    bh_wdata, nx_wdata;
  logic [PW-1:0]    ent_waddr, ent_raddr, nx_waddr, nx_raddr;
  logic [LW-1:0]    bh_rd_r, nx_rd_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] dat_rd_r;

  back_state_t      state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [LW-1:0]    cur_r, cur_nxt, prev_r, prev_nxt;
  logic [LW-1:0]    free_r, free_nxt, fresh_r, fresh_nxt;
  logic [BW-1:0]    clr_r, clr_nxt;
  status_t          res_st_r, res_st_nxt;
  logic [VAL_W-1:0] res_val_r, res_val_nxt;
  logic             ov_r, ov_nxt;
  status_t          os_r, os_nxt;
  logic [VAL_W-1:0] oval_r, oval_nxt;
  logic [BW-1:0]    bkt;

  always_ff @(posedge clk) begin
    if (bh_we) begin
      bh_mem[bh_waddr] <= bh_wdata;
    end
    bh_rd_r <= bh_mem[bh_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      key_mem[ent_waddr] <= req_r.key;
      dat_mem[ent_waddr] <= req_r.value;
    end
    key_rd_r <= key_mem[ent_raddr];
    dat_rd_r <= dat_mem[ent_raddr];
  end

  always_ff @(posedge clk) begin
    if (nx_we) begin
      nx_mem[nx_waddr] <= nx_wdata;
    end
    nx_rd_r <= nx_mem[nx_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      free_r  <= '0;
      fresh_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      free_r  <= free_nxt;
      fresh_r <= fresh_nxt;
      ov_r    <= ov_nxt;
    end
    req_r     <= req_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    os_r      <= os_nxt;
    oval_r    <= oval_nxt;
  end

  always_comb begin
    bkt         = BW'(req_r.bucket);
    state_nxt   = state_r;
    req_nxt     = req_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    free_nxt    = free_r;
    fresh_nxt   = fresh_r;
    clr_nxt     = clr_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    ov_nxt      = ov_r;
    os_nxt      = os_r;
    oval_nxt    = oval_r;
    q_pop       = 1'b0;
    bh_we       = 1'b0;
    bh_waddr    = bkt;
    bh_wdata    = LINK_NULL;
    bh_raddr    = bkt;
    ent_we      = 1'b0;
    ent_waddr   = free_r[PW-1:0];
    ent_raddr   = cur_r[PW-1:0];
    nx_we       = 1'b0;
    nx_waddr    = cur_r[PW-1:0];
    nx_wdata    = free_r;
    nx_raddr    = free_r[PW-1:0];
    stat.clearing = (state_r == B_CLEAR);

    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (state_r)
      B_CLEAR: begin
        bh_we    = 1'b1;
        bh_waddr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == BW'(NUM_BUCKETS - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          req_nxt   = q_data;
          state_nxt = B_HEAD;
        end
      end
      B_HEAD: begin
        res_st_nxt  = ST_MISSING;
        res_val_nxt = '0;
        case (mode_t'(req_r.mode))
          MODE_LOOKUP, MODE_DELETE: begin
            state_nxt = B_LINK;
          end
          MODE_INSERT: begin
            if (free_r >= LINK_NULL) begin
              res_st_nxt = ST_FULL;
              state_nxt  = B_DONE;
            end else begin
              state_nxt = B_INS;
            end
          end
          default: begin
            state_nxt = B_DONE;
          end
        endcase
      end
      B_LINK: begin
        prev_nxt  = LINK_NULL;
        cur_nxt   = bh_rd_r;
        ent_raddr = bh_rd_r[PW-1:0];
        nx_raddr  = bh_rd_r[PW-1:0];
        state_nxt = (bh_rd_r >= LINK_NULL) ? B_DONE : B_CMP;
      end
      B_CMP: begin
        if (key_rd_r == req_r.key) begin
          res_st_nxt  = ST_OK;
          res_val_nxt = dat_rd_r;
          state_nxt   = B_DONE;
          if (mode_t'(req_r.mode) == MODE_DELETE) begin
            state_nxt = B_FREE;
            if (prev_r >= LINK_NULL) begin
              bh_we    = 1'b1;
              bh_wdata = nx_rd_r;
            end else begin
              nx_we    = 1'b1;
              nx_waddr = prev_r[PW-1:0];
              nx_wdata = nx_rd_r;
            end
          end
        end else begin
          prev_nxt  = cur_r;
          cur_nxt   = nx_rd_r;
          ent_raddr = nx_rd_r[PW-1:0];
          nx_raddr  = nx_rd_r[PW-1:0];
          if (nx_rd_r >= LINK_NULL) begin
            state_nxt = B_DONE;
          end
        end
      end
      B_FREE: begin
        nx_we     = 1'b1;
        free_nxt  = cur_r;
        state_nxt = B_DONE;
      end
      B_INS: begin
        ent_we   = 1'b1;
        nx_we    = 1'b1;
        nx_waddr = free_r[PW-1:0];
        nx_wdata = bh_rd_r;
        bh_we    = 1'b1;
        bh_wdata = free_r;
        if (free_r == fresh_r) begin
          free_nxt  = free_r + 1'b1;
          fresh_nxt = fresh_r + 1'b1;
        end else begin
          free_nxt = nx_rd_r;
        end
        res_st_nxt = ST_OK;
        state_nxt  = B_DONE;
      end
      B_DONE: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          os_nxt    = res_st_r;
          oval_nxt  = res_val_r;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = os_r;
  assign out_ch.found_value = oval_r;

endmodule
`default_nettype wire
